[rtl/dtbc_pkg.sv]
// shared constants, types and helper functions for the broadcast time codec
package dtbc_pkg;

  // stages inside the datapath modules; the top level adds one output stage
  localparam int MSTG = 8;

  typedef struct packed {
    logic [MSTG-1:0] ld;
  } pipe_ctrl_t;

  // operation codes
  localparam logic [1:0] FUNC_DATE    = 2'd0;
  localparam logic [1:0] FUNC_DUR2SEC = 2'd1;
  localparam logic [1:0] FUNC_SEC2DUR = 2'd2;

  // date path, year term: (20*mjd - 301564) / 7305
  localparam logic [15:0] MJD_MIN   = 16'd15079;
  localparam logic [20:0] YP_OFS    = 21'd301564;
  localparam logic [20:0] YP_DIV    = 21'd7305;
  localparam logic [19:0] RECIP_Y   = 20'((64'd1 << 32) / 64'd7305);
  localparam logic [18:0] A_MUL     = 19'd1461;
  localparam logic [17:0] MJD_BASE  = 18'd14956;
  // date path, month term: (10000*t - 1000) / 306001
  localparam logic [22:0] T_SCALE   = 23'd10000;
  localparam logic [22:0] T_OFS     = 23'd1000;
  localparam logic [23:0] M_DIV     = 24'd306001;
  localparam logic [13:0] RECIP_M   = 14'((64'd1 << 32) / 64'd306001);
  localparam logic [10:0] YEAR_BASE = 11'd1900;

  // time of day and unix time
  localparam logic [32:0] SEC_DAY   = 33'd86400;
  localparam logic [32:0] UNIX_OFS  = 33'(64'd40587 * 64'd86400);
  localparam logic [19:0] SEC_HOUR  = 20'd3600;
  localparam logic [19:0] SEC_MIN   = 20'd60;

  // seconds to duration: secs/3600 = (secs>>4)/225
  localparam logic [27:0] H_DIV     = 28'd225;
  localparam logic [24:0] RECIP_H   = 25'((64'd1 << 32) / 64'd225);
  localparam logic [11:0] MIN_DIV   = 12'd60;
  localparam logic [12:0] RECIP_MIN = 13'((64'd1 << 18) / 64'd60);
  localparam logic [19:0] BCD_MAX   = 20'd99;

  // bcd byte weighted as tens and units, nibbles unchecked
  function automatic logic [7:0] bcd_val(input logic [7:0] b);
    return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
  endfunction

  // value 0..99 to bcd byte
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    ones = v - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
    return {tens, ones[3:0]};
  endfunction

  // floor(mp * 30.6001)
  function automatic logic [8:0] mon_days(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd30;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd91;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd183;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd244;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd336;
      4'd12:   d = 9'd367;
      4'd13:   d = 9'd397;
      4'd14:   d = 9'd428;
      4'd15:   d = 9'd459;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/dtbc_date.sv]
// mjd to calendar date pipeline, eight stages
module dtbc_date import dtbc_pkg::*; (
  input  logic        clk,
  input  pipe_ctrl_t  ctrl,
  input  logic [15:0] mjd,
  output logic        date_valid,
  output logic [10:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);

  // stage 0: scaled year numerator
  logic [20:0] xw;
  logic [19:0] x0_nxt, x0_r;
  logic [15:0] mjd0_r;
  logic        ok0_nxt, ok0_r;
  // stage 1: reciprocal product
  logic [39:0] prod1_nxt, prod1_r;
  logic [19:0] x1_r;
  logic [15:0] mjd1_r;
  logic        ok1_r;
  // stage 2: year quotient with correction
  logic [7:0]  yp0;
  logic [20:0] rem2;
  logic [7:0]  yp2_nxt, yp2_r;
  logic [15:0] mjd2_r;
  logic        ok2_r;
  // stage 3: int(yp * 365.25)
  logic [18:0] a_prod;
  logic [16:0] a3_nxt, a3_r;
  logic [7:0]  yp3_r;
  logic [15:0] mjd3_r;
  logic        ok3_r;
  // stage 4: day in year and month numerator
  logic [17:0] t_full;
  logic [8:0]  t4_nxt, t4_r;
  logic [22:0] num4_nxt, num4_r;
  logic [7:0]  yp4_r;
  logic        ok4_r;
  // stage 5: month reciprocal product
  logic [36:0] prod5_nxt, prod5_r;
  logic [22:0] num5_r;
  logic [8:0]  t5_r;
  logic [7:0]  yp5_r;
  logic        ok5_r;
  // stage 6: month quotient with correction
  logic [4:0]  mp0;
  logic [23:0] rem6;
  logic [4:0]  mp6_nxt, mp6_r;
  logic [8:0]  t6_r;
  logic [7:0]  yp6_r;
  logic        ok6_r;
  // stage 7: final fields
  logic [8:0]  b7;
  logic        k7;
  logic [8:0]  d7;
  logic [4:0]  mon7;
  logic        valid_nxt, valid_r;
  logic [10:0] year_nxt, year_r;
  logic [3:0]  month_nxt, month_r;
  logic [4:0]  day_nxt, day_r;

  assign xw      = 21'({mjd, 4'b0000}) + 21'({mjd, 2'b00}) - YP_OFS;
  assign x0_nxt  = xw[19:0];
  assign ok0_nxt = (mjd >= MJD_MIN);

  assign prod1_nxt = 40'(x0_r) * 40'(RECIP_Y);

  assign yp0     = prod1_r[39:32];
  assign rem2    = 21'(x1_r) - 21'(yp0) * YP_DIV;
  assign yp2_nxt = yp0 + 8'(rem2 >= YP_DIV);

  assign a_prod = 19'(yp2_r) * A_MUL;
  assign a3_nxt = a_prod[18:2];

  assign t_full   = 18'(mjd3_r) - MJD_BASE - 18'(a3_r);
  assign t4_nxt   = t_full[8:0];
  assign num4_nxt = 23'(t4_nxt) * T_SCALE - T_OFS;

  assign prod5_nxt = 37'(num4_r) * 37'(RECIP_M);

  assign mp0     = prod5_r[36:32];
  assign rem6    = 24'(num5_r) - 24'(mp0) * M_DIV;
  assign mp6_nxt = mp0 + 5'(rem6 >= M_DIV);

  // months 14 and 15 roll into january and february of the next year
  assign b7        = mon_days(mp6_r[3:0]);
  assign k7        = (mp6_r == 5'd14) || (mp6_r == 5'd15);
  assign d7        = t6_r - b7;
  assign mon7      = mp6_r - 5'd1 - (k7 ? 5'd12 : 5'd0);
  assign valid_nxt = ok6_r;
  assign year_nxt  = ok6_r ? (YEAR_BASE + 11'(yp6_r) + 11'(k7)) : 11'd0;
  assign month_nxt = ok6_r ? mon7[3:0] : 4'd0;
  assign day_nxt   = ok6_r ? d7[4:0] : 5'd0;

  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      x0_r   <= x0_nxt;
      mjd0_r <= mjd;
      ok0_r  <= ok0_nxt;
    end
    if (ctrl.ld[1]) begin
      prod1_r <= prod1_nxt;
      x1_r    <= x0_r;
      mjd1_r  <= mjd0_r;
      ok1_r   <= ok0_r;
    end
    if (ctrl.ld[2]) begin
      yp2_r  <= yp2_nxt;
      mjd2_r <= mjd1_r;
      ok2_r  <= ok1_r;
    end
    if (ctrl.ld[3]) begin
      a3_r   <= a3_nxt;
      yp3_r  <= yp2_r;
      mjd3_r <= mjd2_r;
      ok3_r  <= ok2_r;
    end
    if (ctrl.ld[4]) begin
      t4_r   <= t4_nxt;
      num4_r <= num4_nxt;
      yp4_r  <= yp3_r;
      ok4_r  <= ok3_r;
    end
    if (ctrl.ld[5]) begin
      prod5_r <= prod5_nxt;
      num5_r  <= num4_r;
      t5_r    <= t4_r;
      yp5_r   <= yp4_r;
      ok5_r   <= ok4_r;
    end
    if (ctrl.ld[6]) begin
      mp6_r <= mp6_nxt;
      t6_r  <= t5_r;
      yp6_r <= yp5_r;
      ok6_r <= ok5_r;
    end
    if (ctrl.ld[7]) begin
      valid_r <= valid_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
    end
  end

  assign date_valid = valid_r;
  assign year       = year_r;
  assign month      = month_r;
  assign day        = day_r;

endmodule

[rtl/dtbc_clock.sv]
// bcd time of day decode, unix seconds and duration-to-seconds pipeline
module dtbc_clock import dtbc_pkg::*; (
  input  logic        clk,
  input  pipe_ctrl_t  ctrl,
  input  logic [1:0]  func,
  input  logic [39:0] dvb_time,
  input  logic [23:0] duration_bcd,
  output logic [7:0]  hour,
  output logic [7:0]  minute,
  output logic [7:0]  second,
  output logic [32:0] unix_seconds,
  output logic [19:0] tod
);

  typedef struct packed {
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [32:0] unix;
    logic [19:0] tod;
  } tword_t;

  logic [23:0] src;
  logic [7:0]  h0_nxt, m0_nxt, s0_nxt;
  logic [7:0]  h0_r, m0_r, s0_r;
  logic [15:0] mjd0_r;
  logic [19:0] tod1_nxt, tod1_r;
  logic [32:0] day1_nxt, day1_r;
  logic [7:0]  h1_r, m1_r, s1_r;
  tword_t      st_nxt;
  tword_t      st_r [2:MSTG-1];

  // duration words share the bcd decode with the date word
  assign src    = (func == FUNC_DUR2SEC) ? duration_bcd : dvb_time[23:0];
  assign h0_nxt = bcd_val(src[23:16]);
  assign m0_nxt = bcd_val(src[15:8]);
  assign s0_nxt = bcd_val(src[7:0]);

  assign tod1_nxt = 20'(h0_r) * SEC_HOUR + 20'(m0_r) * SEC_MIN + 20'(s0_r);
  assign day1_nxt = 33'(mjd0_r) * SEC_DAY;

  always_comb begin
    st_nxt.hour   = h1_r;
    st_nxt.minute = m1_r;
    st_nxt.second = s1_r;
    st_nxt.unix   = day1_r - UNIX_OFS + 33'(tod1_r);
    st_nxt.tod    = tod1_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      h0_r   <= h0_nxt;
      m0_r   <= m0_nxt;
      s0_r   <= s0_nxt;
      mjd0_r <= dvb_time[39:24];
    end
    if (ctrl.ld[1]) begin
      tod1_r <= tod1_nxt;
      day1_r <= day1_nxt;
      h1_r   <= h0_r;
      m1_r   <= m0_r;
      s1_r   <= s0_r;
    end
    if (ctrl.ld[2]) begin
      st_r[2] <= st_nxt;
    end
    for (int k = 3; k < MSTG; k++) begin
      if (ctrl.ld[k]) begin
        st_r[k] <= st_r[k-1];
      end
    end
  end

  assign hour         = st_r[MSTG-1].hour;
  assign minute       = st_r[MSTG-1].minute;
  assign second       = st_r[MSTG-1].second;
  assign unix_seconds = st_r[MSTG-1].unix;
  assign tod          = st_r[MSTG-1].tod;

endmodule

[rtl/dtbc_dur.sv]
// seconds to bcd duration pipeline
module dtbc_dur import dtbc_pkg::*; (
  input  logic        clk,
  input  pipe_ctrl_t  ctrl,
  input  logic [30:0] seconds_in,
  output logic [23:0] duration_out
);

  logic [26:0] q0_r;
  logic [3:0]  lo0_r;
  logic [51:0] prod1_nxt, prod1_r;
  logic [26:0] q1_r;
  logic [3:0]  lo1_r;
  logic [19:0] h0;
  logic [27:0] rem2;
  logic        fix2;
  logic [19:0] h2_nxt, h2_r;
  logic [7:0]  r2_nxt, r2_r;
  logic [3:0]  lo2_r;
  logic [11:0] rest3;
  logic [24:0] mprod3;
  logic [6:0]  m3_nxt, m3_r;
  logic [11:0] rest3_r;
  logic [6:0]  h3_nxt, h3_r;
  logic [11:0] rem4;
  logic        fix4;
  logic [6:0]  m4_nxt, m4_r;
  logic [6:0]  s4_nxt, s4_r;
  logic [6:0]  h4_r;
  logic [23:0] bcd5_nxt;
  logic [23:0] bcd_r [5:MSTG-1];

  // hours: (secs >> 4) / 225, reciprocal estimate is low by at most one
  assign prod1_nxt = 52'(q0_r) * 52'(RECIP_H);

  assign h0     = prod1_r[51:32];
  assign rem2   = 28'(q1_r) - 28'(h0) * H_DIV;
  assign fix2   = (rem2 >= H_DIV);
  assign h2_nxt = h0 + 20'(fix2);
  assign r2_nxt = fix2 ? 8'(rem2 - H_DIV) : rem2[7:0];

  // remainder within the hour, then minutes by reciprocal of 60
  assign rest3  = {r2_r, lo2_r};
  assign mprod3 = 25'(rest3) * 25'(RECIP_MIN);
  assign m3_nxt = mprod3[24:18];
  // hours outside 0..99 encode as zero
  assign h3_nxt = (h2_r > BCD_MAX) ? 7'd0 : h2_r[6:0];

  assign rem4   = rest3_r - 12'(m3_r) * MIN_DIV;
  assign fix4   = (rem4 >= MIN_DIV);
  assign m4_nxt = m3_r + 7'(fix4);
  assign s4_nxt = fix4 ? 7'(rem4 - MIN_DIV) : rem4[6:0];

  assign bcd5_nxt = {to_bcd(h4_r), to_bcd(m4_r), to_bcd(s4_r)};

  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      q0_r  <= seconds_in[30:4];
      lo0_r <= seconds_in[3:0];
    end
    if (ctrl.ld[1]) begin
      prod1_r <= prod1_nxt;
      q1_r    <= q0_r;
      lo1_r   <= lo0_r;
    end
    if (ctrl.ld[2]) begin
      h2_r  <= h2_nxt;
      r2_r  <= r2_nxt;
      lo2_r <= lo1_r;
    end
    if (ctrl.ld[3]) begin
      m3_r    <= m3_nxt;
      rest3_r <= rest3;
      h3_r    <= h3_nxt;
    end
    if (ctrl.ld[4]) begin
      m4_r <= m4_nxt;
      s4_r <= s4_nxt;
      h4_r <= h3_r;
    end
    if (ctrl.ld[5]) begin
      bcd_r[5] <= bcd5_nxt;
    end
    for (int k = 6; k < MSTG; k++) begin
      if (ctrl.ld[k]) begin
        bcd_r[k] <= bcd_r[k-1];
      end
    end
  end

  assign duration_out = bcd_r[MSTG-1];

endmodule

[rtl/dvb_time_bcd_codec_top.sv]
// top level of the broadcast time and bcd duration codec
//
// one word in, one word out, no state between words. in_func picks the
// operation: 0 splits a 40-bit broadcast utc word (16-bit mjd, bcd hour,
// minute, second) into year, month, day, decoded time fields and signed
// utc seconds since 1970; 1 turns a bcd hh:mm:ss duration into seconds;
// 2 turns seconds into a bcd hh:mm:ss duration, hours above 99 giving 00.
// fields that do not belong to the chosen operation read as zero, and
// code 3 gives an all-zero word. an mjd below 15079 clears date_valid and
// the date fields while time fields and unix seconds are still given.
// the datapath is nine register stages deep, and a new word can be
// accepted at every clock unless a stall on out_ready has filled every
// stage. each stage holds its own valid bit and loads whenever it is
// empty or its successor moves, so bubbles close up and in_ready stays
// high while a finished word waits on out_ready as long as some stage
// is free. no reset-time sweep, words are taken right after reset.
module dvb_time_bcd_codec_top import dtbc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [39:0]        in_dvb_time,
  input  logic [23:0]        in_duration_bcd,
  input  logic [30:0]        in_seconds_in,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_date_valid,
  output logic [10:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [7:0]         out_hour,
  output logic [7:0]         out_minute,
  output logic [7:0]         out_second,
  output logic signed [32:0] out_unix_seconds,
  output logic [19:0]        out_total_seconds,
  output logic [23:0]        out_duration_out
);

  // stage control: ld[i] loads stage i, ld[MSTG] loads the output register
  logic [MSTG:0]   ld;
  logic [MSTG-1:0] v_r, v_nxt;
  logic            out_valid_r, out_valid_nxt;
  pipe_ctrl_t      ctrl;
  logic [1:0]      func_r [MSTG];

  // datapath results at the last internal stage
  logic        dt_valid;
  logic [10:0] dt_year;
  logic [3:0]  dt_month;
  logic [4:0]  dt_day;
  logic [7:0]  ck_hour, ck_minute, ck_second;
  logic [32:0] ck_unix;
  logic [19:0] ck_tod;
  logic [23:0] du_word;

  // output register
  logic        date_valid_nxt, date_valid_r;
  logic [10:0] year_nxt, year_r;
  logic [3:0]  month_nxt, month_r;
  logic [4:0]  day_nxt, day_r;
  logic [7:0]  hour_nxt, hour_r;
  logic [7:0]  minute_nxt, minute_r;
  logic [7:0]  second_nxt, second_r;
  logic [32:0] unix_nxt, unix_r;
  logic [19:0] total_nxt, total_r;
  logic [23:0] dur_nxt, dur_r;

  // a stage may load when it is empty or when its contents move on
  always_comb begin
    ld[MSTG] = !out_valid_r || out_ready;
    for (int i = MSTG - 1; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  assign in_ready = ld[0];
  assign ctrl.ld  = ld[MSTG-1:0];

  always_comb begin
    v_nxt[0] = ld[0] ? in_valid : v_r[0];
    for (int i = 1; i < MSTG; i++) begin
      v_nxt[i] = ld[i] ? v_r[i-1] : v_r[i];
    end
    out_valid_nxt = ld[MSTG] ? v_r[MSTG-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operation code travels alongside the data
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      func_r[0] <= in_func;
    end
    for (int k = 1; k < MSTG; k++) begin
      if (ld[k]) begin
        func_r[k] <= func_r[k-1];
      end
    end
  end

  dtbc_date u_date (
    .clk        (clk),
    .ctrl       (ctrl),
    .mjd        (in_dvb_time[39:24]),
    .date_valid (dt_valid),
    .year       (dt_year),
    .month      (dt_month),
    .day        (dt_day)
  );

  dtbc_clock u_clock (
    .clk          (clk),
    .ctrl         (ctrl),
    .func         (in_func),
    .dvb_time     (in_dvb_time),
    .duration_bcd (in_duration_bcd),
    .hour         (ck_hour),
    .minute       (ck_minute),
    .second       (ck_second),
    .unix_seconds (ck_unix),
    .tod          (ck_tod)
  );

  dtbc_dur u_dur (
    .clk          (clk),
    .ctrl         (ctrl),
    .seconds_in   (in_seconds_in),
    .duration_out (du_word)
  );

  // select the fields of the chosen operation, the rest read as zero
  always_comb begin
    date_valid_nxt = 1'b0;
    year_nxt       = '0;
    month_nxt      = '0;
    day_nxt        = '0;
    hour_nxt       = '0;
    minute_nxt     = '0;
    second_nxt     = '0;
    unix_nxt       = '0;
    total_nxt      = '0;
    dur_nxt        = '0;
    case (func_r[MSTG-1])
      FUNC_DATE: begin
        date_valid_nxt = dt_valid;
        year_nxt       = dt_year;
        month_nxt      = dt_month;
        day_nxt        = dt_day;
        hour_nxt       = ck_hour;
        minute_nxt     = ck_minute;
        second_nxt     = ck_second;
        unix_nxt       = ck_unix;
      end
      FUNC_DUR2SEC: begin
        total_nxt = ck_tod;
      end
      FUNC_SEC2DUR: begin
        dur_nxt = du_word;
      end
      default: begin
        dur_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[MSTG]) begin
      date_valid_r <= date_valid_nxt;
      year_r       <= year_nxt;
      month_r      <= month_nxt;
      day_r        <= day_nxt;
      hour_r       <= hour_nxt;
      minute_r     <= minute_nxt;
      second_r     <= second_nxt;
      unix_r       <= unix_nxt;
      total_r      <= total_nxt;
      dur_r        <= dur_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_date_valid    = date_valid_r;
  assign out_year          = year_r;
  assign out_month         = month_r;
  assign out_day           = day_r;
  assign out_hour          = hour_r;
  assign out_minute        = minute_r;
  assign out_second        = second_r;
  assign out_unix_seconds  = $signed(unix_r);
  assign out_total_seconds = total_r;
  assign out_duration_out  = dur_r;

endmodule

[rtl/dtbc_checker.sv]
// port-level checks for the time codec, bound to the top level
module dtbc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_date_valid,
  input logic [10:0]        out_year,
  input logic [3:0]         out_month,
  input logic [4:0]         out_day,
  input logic signed [32:0] out_unix_seconds,
  input logic [23:0]        out_duration_out
);

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year)
      && $stable(out_unix_seconds) && $stable(out_duration_out))
    else $error("result word changed while stalled");

  // a flagged date has month 1..12, a nonzero day and a year from 1900 on
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_valid |-> out_month >= 4'd1 && out_month <= 4'd12
      && out_day >= 5'd1 && out_year >= 11'd1900)
    else $error("flagged date out of range");

  // without the flag the date fields are cleared
  a_date_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_date_valid |-> out_year == 11'd0 && out_month == 4'd0
      && out_day == 5'd0)
    else $error("date fields set without date flag");

  // encoded duration is always well-formed bcd
  a_dur_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duration_out[3:0] <= 4'd9 && out_duration_out[7:4] <= 4'd5
      && out_duration_out[11:8] <= 4'd9 && out_duration_out[15:12] <= 4'd5
      && out_duration_out[19:16] <= 4'd9 && out_duration_out[23:20] <= 4'd9)
    else $error("duration word is not bcd");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dvb_time_bcd_codec_top dtbc_checker u_dtbc_checker (.*);
